>>> design/slm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// Shared operation codes, status codes and controller/datapath interface
// types for the two-way sorted list merge.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd1;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd2;
    localparam logic [OP_W-1:0] OP_PULL     = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic            capture;
        logic            clear;
        logic            wr_a;
        logic            wr_b;
        logic            pop_a;
        logic            pop_b;
        logic            emit;
        logic [ST_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic has_a;
        logic has_b;
        logic full_a;
        logic full_b;
        logic a_le_b;
    } t_stat;

endpackage

>>> design/slm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_dp
// Datapath: two list memories, counts, read positions, head compare and
// the result register.
// ----------------------------------------------------------------------------
module slm_dp #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slm_pkg::t_cmd                     i_cmd,
    input  logic signed [slm_pkg::DATA_W-1:0] i_value,
    output slm_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output logic signed [slm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_final_element,
    output logic [slm_pkg::ST_W-1:0]          o_status
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    logic signed [slm_pkg::DATA_W-1:0] r_mem_a [LIST_DEPTH];
    logic signed [slm_pkg::DATA_W-1:0] r_mem_b [LIST_DEPTH];
    logic signed [slm_pkg::DATA_W-1:0] r_rd_a;
    logic signed [slm_pkg::DATA_W-1:0] r_rd_b;
    logic signed [slm_pkg::DATA_W-1:0] r_value;

    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_pos_a, n_pos_a;
    logic [CW-1:0] r_pos_b, n_pos_b;

    logic                              r_valid;
    logic signed [slm_pkg::DATA_W-1:0] r_merged, n_merged;
    logic                              r_final, n_final;
    logic [slm_pkg::ST_W-1:0]          r_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= r_value;
        end
        if (i_cmd.wr_b) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= r_value;
        end
        r_rd_a <= r_mem_a[r_pos_a[AW-1:0]];
        r_rd_b <= r_mem_b[r_pos_b[AW-1:0]];
        if (i_cmd.capture) begin
            r_value <= i_value;
        end
    end

    always_comb begin
        o_stat.has_a  = r_pos_a < r_cnt_a;
        o_stat.has_b  = r_pos_b < r_cnt_b;
        o_stat.full_a = r_cnt_a >= DEPTH_C;
        o_stat.full_b = r_cnt_b >= DEPTH_C;
        o_stat.a_le_b = r_rd_a <= r_rd_b;
    end

    always_comb begin
        n_cnt_a = r_cnt_a + CW'(i_cmd.wr_a);
        n_cnt_b = r_cnt_b + CW'(i_cmd.wr_b);
        n_pos_a = r_pos_a + CW'(i_cmd.pop_a);
        n_pos_b = r_pos_b + CW'(i_cmd.pop_b);
        if (i_cmd.clear) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
            n_pos_a = '0;
            n_pos_b = '0;
        end
        n_merged = '0;
        n_final  = 1'b0;
        if (i_cmd.pop_a || i_cmd.pop_b) begin
            n_merged = i_cmd.pop_a ? r_rd_a : r_rd_b;
            n_final  = (n_pos_a >= r_cnt_a) && (n_pos_b >= r_cnt_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_pos_a <= '0;
            r_pos_b <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_pos_a <= n_pos_a;
            r_pos_b <= n_pos_b;
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_merged <= n_merged;
            r_final  <= n_final;
            r_status <= i_cmd.status;
        end
    end

    assign o_valid         = r_valid;
    assign o_merged_value  = r_merged;
    assign o_final_element = r_final;
    assign o_status        = r_status;

endmodule

>>> design/slm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_ctrl
// Controller: takes a beat, decodes the operation and issues datapath
// commands in the execute cycle.
// ----------------------------------------------------------------------------
module slm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [slm_pkg::OP_W-1:0]  i_operation,
    input  slm_pkg::t_stat            i_stat,
    output slm_pkg::t_cmd             o_cmd,
    output logic                      o_busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                     r_state, n_state;
    logic [slm_pkg::OP_W-1:0] r_op;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.emit   = 1'b1;
                o_cmd.status = slm_pkg::ST_OK;
                n_state      = S_IDLE;
                case (r_op)
                    slm_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    slm_pkg::OP_APPEND_A: begin
                        if (i_stat.full_a) begin
                            o_cmd.status = slm_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_a = 1'b1;
                        end
                    end
                    slm_pkg::OP_APPEND_B: begin
                        if (i_stat.full_b) begin
                            o_cmd.status = slm_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_b = 1'b1;
                        end
                    end
                    default: begin
                        if (!i_stat.has_a && !i_stat.has_b) begin
                            o_cmd.status = slm_pkg::ST_EMPTY;
                        end else if (i_stat.has_a && (!i_stat.has_b || i_stat.a_le_b)) begin
                            o_cmd.pop_a = 1'b1;
                        end else begin
                            o_cmd.pop_b = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.capture) begin
            r_op <= i_operation;
        end
    end

    assign o_busy = (r_state == S_EXEC);

endmodule

>>> design/sorted_list_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_merge
// Two-way stable merge of two ascending lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken when i_start is high and o_busy is low. i_operation picks
//   clear, append to list A, append to list B, or pull; i_value is the element
//   for an append.
//   Every beat gives exactly one result, shown for one cycle with o_valid:
//   o_merged_value, o_final_element and o_status (ok, full, empty).
//   The accepting edge moves the controller into its execute state, and the
//   result of that state is registered onto the ports. o_busy is high for
//   the one execute cycle that follows the accepting edge, so no new beat is
//   taken while the last one executes; the memory read of both list heads is
//   registered first, and the compare and update take place in execute.
//   The next beat may be taken in the cycle that shows the previous result.
//   Reset empties both lists at once (counts and read positions to zero); no
//   clearing pass is needed. The receiver cannot stall, so results are never
//   held back.
// ----------------------------------------------------------------------------
module sorted_list_merge #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [slm_pkg::OP_W-1:0]          i_operation,
    input  logic signed [slm_pkg::DATA_W-1:0] i_value,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic signed [slm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_final_element,
    output logic [slm_pkg::ST_W-1:0]          o_status
);

    slm_pkg::t_cmd  cmd;
    slm_pkg::t_stat stat;

    slm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    slm_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value         (i_value),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_merged_value  (o_merged_value),
        .o_final_element (o_final_element),
        .o_status        (o_status)
    );

    a_accept_to_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted beat did not enter execute");

    a_busy_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> o_valid && !o_busy)
        else $error("execute cycle did not produce one result");

    a_valid_needs_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without execute cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != slm_pkg::ST_OK) |->
            (o_merged_value == '0) && !o_final_element)
        else $error("failed beat carries data");

endmodule
